// ===== hw/rtl/rbaf_pkg.sv =====
// rbaf_pkg: types and constants shared by the RGB box average filter.
// Word layouts, configuration register map, reciprocal constants.
// No dependencies.
package rbaf_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int COORD_W    = 10;
  localparam int COL_SUM_W  = 11;
  localparam int WIN_SUM_W  = 13;

  // floor(s / d) == (s * RECIP) >> DIV_SHIFT for every window sum s
  localparam int                 RECIP_W   = 15;
  localparam int                 DIV_SHIFT = 18;
  localparam logic [RECIP_W-1:0] RECIP_3X3 = 15'd29128;
  localparam logic [RECIP_W-1:0] RECIP_5X5 = 15'd10486;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_LSB = 2;
  localparam logic REG_IMAGE_WIDTH   = 1'b0;
  localparam logic REG_WINDOW_RADIUS = 1'b1;

  localparam int                    IMG_W_BITS  = 11;
  localparam int                    RAD_BITS    = 2;
  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
  localparam logic [RAD_BITS-1:0]   RAD_RESET   = 2'd1;
  localparam logic [RAD_BITS-1:0]   RAD_MIN     = 2'd1;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_CNT_W = 4;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic            frame_start;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0]    red_avg;
    logic [CH_W-1:0]    green_avg;
    logic [CH_W-1:0]    blue_avg;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [COL_SUM_W-1:0] red;
    logic [COL_SUM_W-1:0] green;
    logic [COL_SUM_W-1:0] blue;
  } col_sum_t;

  typedef struct packed {
    logic [WIN_SUM_W-1:0] red;
    logic [WIN_SUM_W-1:0] green;
    logic [WIN_SUM_W-1:0] blue;
  } win_sum_t;

  typedef struct packed {
    logic               valid;
    logic               produce;
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } item_tag_t;

  typedef struct packed {
    logic                shift;
    logic                add_en;
    logic [RAD_BITS-1:0] rad;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/rbaf_line_store.sv =====
// rbaf_line_store: line buffer memory, all buffered lines of one column per word.
// One read and one write port, registered read data, zeroing pass after reset.
// No dependencies.
module rbaf_line_store #(
  parameter int DEPTH  = 1024,
  parameter int WORD_W = 96,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  output logic              clearing
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clearing = clr_busy_r;

endmodule

// ===== hw/rtl/rbaf_cell.sv =====
// rbaf_cell: one window column; holds its column sums for each window size and
// adds the selected one into the running window total. Uses rbaf_pkg.
module rbaf_cell
  import rbaf_pkg::*;
#(
  parameter int NSUM = 2
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  col_sum_t [NSUM-1:0]   col_in,
  output col_sum_t [NSUM-1:0]   col_out,
  input  win_sum_t              part_in,
  output win_sum_t              part_out
);

  col_sum_t [NSUM-1:0] col_r;
  col_sum_t            sel;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_in;
    end
  end

  always_comb begin
    sel = col_r[0];
    for (int j = 1; j < NSUM; j++) begin
      if (ctl.rad == RAD_BITS'(j + 1)) begin
        sel = col_r[j];
      end
    end
    part_out = part_in;
    if (ctl.add_en) begin
      part_out.red   = part_in.red   + WIN_SUM_W'(sel.red);
      part_out.green = part_in.green + WIN_SUM_W'(sel.green);
      part_out.blue  = part_in.blue  + WIN_SUM_W'(sel.blue);
    end
  end

  assign col_out = col_r;

endmodule

// ===== hw/rtl/rbaf_mean.sv =====
// rbaf_mean: registers the window total, divides by 9 or 25 through a
// reciprocal multiply and hands the result word on. Uses rbaf_pkg.
module rbaf_mean
  import rbaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  item_tag_t           tag_in,
  input  win_sum_t            total,
  input  logic [RAD_BITS-1:0] rad,
  output logic                push,
  output result_t             push_data,
  output logic [1:0]          pend
);

  localparam int PROD_W = WIN_SUM_W + RECIP_W;

  item_tag_t           tag_a_r;
  item_tag_t           tag_b_r;
  win_sum_t            tot_a_r;
  logic [PROD_W-1:0]   prod_red_r;
  logic [PROD_W-1:0]   prod_green_r;
  logic [PROD_W-1:0]   prod_blue_r;
  logic [RECIP_W-1:0]  recip;

  assign recip = (rad == RAD_MIN) ? RECIP_3X3 : RECIP_5X5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (tag_in.valid) begin
      tot_a_r <= total;
    end
    if (tag_a_r.valid) begin
      prod_red_r   <= PROD_W'(tot_a_r.red)   * PROD_W'(recip);
      prod_green_r <= PROD_W'(tot_a_r.green) * PROD_W'(recip);
      prod_blue_r  <= PROD_W'(tot_a_r.blue)  * PROD_W'(recip);
    end
  end

  always_comb begin
    push_data.red_avg   = prod_red_r[DIV_SHIFT +: CH_W];
    push_data.green_avg = prod_green_r[DIV_SHIFT +: CH_W];
    push_data.blue_avg  = prod_blue_r[DIV_SHIFT +: CH_W];
    push_data.center_x  = tag_b_r.center_x;
    push_data.center_y  = tag_b_r.center_y;
  end

  assign push = tag_b_r.valid && tag_b_r.produce;
  assign pend = {tag_a_r.produce, tag_b_r.produce};

endmodule

// ===== hw/rtl/rbaf_out_queue.sv =====
// rbaf_out_queue: small result queue between the filter pipeline and the
// output channel; reports its fill level for input flow control. Uses rbaf_pkg.
module rbaf_out_queue
  import rbaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  result_t             push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output result_t             out_data,
  output logic [OQ_CNT_W-1:0] count
);

  localparam int PW = $clog2(OQ_DEPTH);

  result_t             entry_r [OQ_DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [OQ_CNT_W-1:0] count_r;
  logic                pop;

  assign out_valid = (count_r != '0);
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign out_data = entry_r[rd_ptr_r];
  assign count    = count_r;

endmodule

// ===== hw/rtl/rgb_box_average_filter.sv =====
// rgb_box_average_filter: top level of the 3x3 / 5x5 RGB box average filter.
// Uses rbaf_pkg, rbaf_line_store, rbaf_cell, rbaf_mean, rbaf_out_queue.
//
// Takes one pixel word per clock in raster order while in_ready is high, and
// returns, for every pixel whose window lies inside the image, the truncated
// per-channel window mean and the window centre; border pixels give no result
// word. A result word passes the s1 and s2 tag registers and the two in
// rbaf_mean before it enters the result queue, at its head if the queue was
// empty. The rate of one pixel per clock is set by the line store, which does
// one read and one write per cycle, and by the row of window cells that shift
// once per pixel. An 8-word result queue decouples the output: in_ready drops
// when queued plus in-flight results would overflow it. After reset the line
// store is zeroed, one column per cycle, over all MAX_WIDTH columns; in_ready
// stays low during that pass while register writes are taken as usual.
module rgb_box_average_filter
  import rbaf_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_RADIUS = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output result_t               out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int CW     = AW + 1;
  localparam int HW     = $clog2(MAX_HEIGHT);
  localparam int EW     = (CW > IMG_W_BITS) ? CW : IMG_W_BITS;
  localparam int XW     = (AW > COORD_W) ? AW : COORD_W;
  localparam int YW     = (HW > COORD_W) ? HW : COORD_W;
  localparam int NLINES = 2 * MAX_RADIUS;
  localparam int WDIM   = 2 * MAX_RADIUS + 1;
  localparam int WORD_W = NLINES * PIX_W;

  // configuration
  logic [IMG_W_BITS-1:0] image_width_r;
  logic [RAD_BITS-1:0]   window_radius_r;
  logic                  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= IMG_W_RESET;
      window_radius_r <= RAD_RESET;
    end else if (cfg_wr) begin
      case (paddr[CFG_IDX_LSB])
        REG_IMAGE_WIDTH:   image_width_r   <= pwdata[IMG_W_BITS-1:0];
        REG_WINDOW_RADIUS: window_radius_r <= pwdata[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_IDX_LSB])
      REG_IMAGE_WIDTH:   prdata = CFG_DATA_W'(image_width_r);
      REG_WINDOW_RADIUS: prdata = CFG_DATA_W'(window_radius_r);
      default:           prdata = '0;
    endcase
  end

  // effective width and radius
  logic [EW-1:0]       w_ext;
  logic [CW-1:0]       w_eff;
  logic [RAD_BITS-1:0] rad;
  logic [2:0]          two_r;

  always_comb begin
    w_ext = EW'(image_width_r);
    if (w_ext > EW'(MAX_WIDTH)) begin
      w_ext = EW'(MAX_WIDTH);
    end else if (w_ext == '0) begin
      w_ext = EW'(1);
    end
    w_eff = w_ext[CW-1:0];
    rad   = window_radius_r;
    if (rad == '0) begin
      rad = RAD_MIN;
    end else if (rad > RAD_BITS'(MAX_RADIUS)) begin
      rad = RAD_BITS'(MAX_RADIUS);
    end
    two_r = {rad, 1'b0};
  end

  // position counters
  logic [AW-1:0] col_r;
  logic [AW-1:0] col_nxt;
  logic [AW-1:0] c0;
  logic [AW-1:0] c1;
  logic [CW-1:0] c2;
  logic [HW-1:0] row_r;
  logic [HW-1:0] row_nxt;
  logic [HW-1:0] r0;
  logic [HW-1:0] r1;
  logic          produce;
  logic [XW-1:0] cx_full;
  logic [YW-1:0] cy_full;
  logic          in_acc;

  function automatic logic [HW-1:0] row_step(input logic [HW-1:0] r);
    row_step = (r < HW'(MAX_HEIGHT - 1)) ? r + 1'b1 : r;
  endfunction

  always_comb begin
    c0 = in_data.frame_start ? '0 : col_r;
    r0 = in_data.frame_start ? '0 : row_r;
    if (CW'(c0) >= w_eff) begin
      c1 = '0;
      r1 = row_step(r0);
    end else begin
      c1 = c0;
      r1 = r0;
    end
    produce = (c1 >= AW'(two_r)) && (r1 >= HW'(two_r));
    cx_full = XW'(c1) - XW'(rad);
    cy_full = YW'(r1) - YW'(rad);
    c2      = CW'(c1) + 1'b1;
    if (c2 >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_step(r1);
    end else begin
      col_nxt = c2[AW-1:0];
      row_nxt = r1;
    end
  end

  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // line store
  logic [WORD_W-1:0] mem_rdata;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic              clr_busy;
  item_tag_t         s1_tag_r;
  item_tag_t         s2_tag_r;
  rgb_t              s1_pix_r;
  logic [AW-1:0]     s1_col_r;
  logic              s1_byp_r;
  logic [WORD_W-1:0] byp_word_r;

  rbaf_line_store #(
    .DEPTH  (MAX_WIDTH),
    .WORD_W (WORD_W)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_addr  (c1),
    .rd_data  (mem_rdata),
    .wr_en    (s1_tag_r.valid),
    .wr_addr  (s1_col_r),
    .wr_data  (wr_word),
    .clearing (clr_busy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else begin
      s1_tag_r.valid    <= in_acc;
      s1_tag_r.produce  <= in_acc && produce;
      s1_tag_r.center_x <= cx_full[COORD_W-1:0];
      s1_tag_r.center_y <= cy_full[COORD_W-1:0];
      s2_tag_r          <= s1_tag_r;
    end
  end

  // same column written back this cycle: forward the written word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix_r.red   <= in_data.red_in;
      s1_pix_r.green <= in_data.green_in;
      s1_pix_r.blue  <= in_data.blue_in;
      s1_col_r       <= c1;
      s1_byp_r       <= s1_tag_r.valid && (s1_col_r == c1);
      byp_word_r     <= wr_word;
    end
  end

  assign rd_word = s1_byp_r ? byp_word_r : mem_rdata;
  assign wr_word = {rd_word[WORD_W-PIX_W-1:0], s1_pix_r};

  // column vector and its sums for each window size
  rgb_t     [WDIM-1:0]       col_vec;
  col_sum_t [MAX_RADIUS-1:0] new_sum;

  always_comb begin
    col_vec[0] = s1_pix_r;
    for (int k = 0; k < NLINES; k++) begin
      col_vec[k+1] = rgb_t'(rd_word[k*PIX_W +: PIX_W]);
    end
    for (int j = 0; j < MAX_RADIUS; j++) begin
      new_sum[j] = '0;
      for (int k = 0; k <= 2 * j + 2; k++) begin
        new_sum[j].red   = new_sum[j].red   + COL_SUM_W'(col_vec[k].red);
        new_sum[j].green = new_sum[j].green + COL_SUM_W'(col_vec[k].green);
        new_sum[j].blue  = new_sum[j].blue  + COL_SUM_W'(col_vec[k].blue);
      end
    end
  end

  // window cells, oldest column at index 0
  col_sum_t [WDIM-1:0][MAX_RADIUS-1:0] chain;
  win_sum_t [WDIM:0]                   part;

  assign part[0] = '0;

  for (genvar c = 0; c < WDIM; c++) begin : g_cell
    cell_ctl_t                 ctl;
    col_sum_t [MAX_RADIUS-1:0] feed;

    assign ctl.shift  = s1_tag_r.valid;
    assign ctl.add_en = (3'(WDIM - 1 - c) <= two_r);
    assign ctl.rad    = rad;

    if (c == WDIM - 1) begin : g_head
      assign feed = new_sum;
    end else begin : g_body
      assign feed = chain[c+1];
    end

    rbaf_cell #(
      .NSUM (MAX_RADIUS)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .col_in   (feed),
      .col_out  (chain[c]),
      .part_in  (part[c]),
      .part_out (part[c+1])
    );
  end

  // division and result queue
  logic                push;
  result_t             push_data;
  logic [1:0]          mean_pend;
  logic [OQ_CNT_W-1:0] oq_count;
  logic [OQ_CNT_W-1:0] pend_cnt;

  rbaf_mean u_mean (
    .clk       (clk),
    .rst_n     (rst_n),
    .tag_in    (s2_tag_r),
    .total     (part[WDIM]),
    .rad       (rad),
    .push      (push),
    .push_data (push_data),
    .pend      (mean_pend)
  );

  rbaf_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (oq_count)
  );

  assign pend_cnt = OQ_CNT_W'(s1_tag_r.produce) + OQ_CNT_W'(s2_tag_r.produce)
                  + OQ_CNT_W'(mean_pend[0]) + OQ_CNT_W'(mean_pend[1]);

  assign in_ready = !clr_busy && ((oq_count + pend_cnt) < OQ_CNT_W'(OQ_DEPTH));

endmodule

// ===== hw/rtl/rbaf_checker.sv =====
// rbaf_checker: port-level assertions for rgb_box_average_filter, bound to it.
// Uses rbaf_pkg.
module rbaf_checker
  import rbaf_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input result_t               out_data,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [CFG_ADDR_W-1:0] paddr,
  input logic [CFG_DATA_W-1:0] pwdata,
  input logic [CFG_DATA_W-1:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ports not quiet after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 5))
    else $error("result word without pixel word five cycles before");

  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite |=>
      (paddr[CFG_IDX_LSB] != $past(paddr[CFG_IDX_LSB])) ||
      ((paddr[CFG_IDX_LSB] == REG_WINDOW_RADIUS) &&
       (prdata == CFG_DATA_W'($past(pwdata[RAD_BITS-1:0])))) ||
      ((paddr[CFG_IDX_LSB] == REG_IMAGE_WIDTH) &&
       (prdata == CFG_DATA_W'($past(pwdata[IMG_W_BITS-1:0])))))
    else $error("register readback mismatch");

endmodule

bind rgb_box_average_filter rbaf_checker u_rbaf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);
